@@ rtl/sgr_pkg.sv @@
// Package for the SGR color attribute parser: item types, character codes
// and the functions that apply an SGR parameter to a console attribute word.
// Used by the top level and by its checker; depends on nothing else.
`default_nettype none

package sgr_pkg;

   // Widths of the item fields and of the internal words.
   localparam int unsigned AttrWidth  = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned ParamWidth = 16;
   // Room for param * 10 + 9 before saturation.
   localparam int unsigned ProdWidth  = 20;

   // Character codes of the sequence.
   localparam logic [ByteWidth-1:0] CharZero   = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine   = 8'h39;
   localparam logic [ByteWidth-1:0] CharSemi   = 8'h3B;
   localparam logic [ByteWidth-1:0] CharUpperA = 8'h41;
   localparam logic [ByteWidth-1:0] CharUpperZ = 8'h5A;
   localparam logic [ByteWidth-1:0] CharLowerA = 8'h61;
   localparam logic [ByteWidth-1:0] CharLowerZ = 8'h7A;
   localparam logic [ByteWidth-1:0] CharM      = 8'h6D;

   localparam logic [ParamWidth-1:0] ParamMax    = 16'hFFFF;
   localparam logic [AttrWidth-1:0]  DefaultAttr = 16'h0007;
   localparam logic [AttrWidth-1:0]  FgMask      = 16'h000F;
   localparam logic [AttrWidth-1:0]  BgMask      = 16'h00F0;

   // SGR parameter codes.
   localparam logic [ParamWidth-1:0] CodeReset   = 16'd0;
   localparam logic [ParamWidth-1:0] CodeFgLo    = 16'd30;
   localparam logic [ParamWidth-1:0] CodeFgHi    = 16'd37;
   localparam logic [ParamWidth-1:0] CodeFgDef   = 16'd39;
   localparam logic [ParamWidth-1:0] CodeBgLo    = 16'd40;
   localparam logic [ParamWidth-1:0] CodeBgHi    = 16'd47;
   localparam logic [ParamWidth-1:0] CodeBgDef   = 16'd49;
   localparam logic [ParamWidth-1:0] CodeFgBrLo  = 16'd90;
   localparam logic [ParamWidth-1:0] CodeFgBrHi  = 16'd97;
   localparam logic [ParamWidth-1:0] CodeBgBrLo  = 16'd100;
   localparam logic [ParamWidth-1:0] CodeBgBrHi  = 16'd107;

   // One input item.
   typedef struct packed {
      logic [ByteWidth-1:0] seq_byte;
      logic                 seq_start;
   } sgr_req_type;

   // One result item.
   typedef struct packed {
      logic [AttrWidth-1:0] attr_value;
      logic [ByteWidth-1:0] final_byte;
      logic                 applied;
   } sgr_rsp_type;

   // SGR color index to console bits: red 4, green 2, blue 1.
   function automatic logic [2:0] color_bits(input logic [2:0] idx);
      logic [2:0] bits;
      bits = {idx[0], idx[1], idx[2]};
      return bits;
   endfunction

   // Apply one SGR parameter to an attribute word. Unknown codes change nothing.
   function automatic logic [AttrWidth-1:0] apply_code(
      input logic [AttrWidth-1:0]  attr,
      input logic [ParamWidth-1:0] code,
      input logic [AttrWidth-1:0]  dflt
   );
      logic [AttrWidth-1:0] res;
      res = attr;
      case (code) inside
         CodeReset: begin
            res = (attr & ~(FgMask | BgMask)) | (dflt & (FgMask | BgMask));
         end
         [CodeFgLo:CodeFgHi]: begin
            res[3:0] = {1'b0, color_bits(code[2:0] - CodeFgLo[2:0])};
         end
         CodeFgDef: begin
            res = (attr & ~FgMask) | (dflt & FgMask);
         end
         [CodeBgLo:CodeBgHi]: begin
            res[7:4] = {1'b0, color_bits(code[2:0] - CodeBgLo[2:0])};
         end
         CodeBgDef: begin
            res = (attr & ~BgMask) | (dflt & BgMask);
         end
         [CodeFgBrLo:CodeFgBrHi]: begin
            res[3:0] = {1'b1, color_bits(code[2:0] - CodeFgBrLo[2:0])};
         end
         [CodeBgBrLo:CodeBgBrHi]: begin
            res[7:4] = {1'b1, color_bits(code[2:0] - CodeBgBrLo[2:0])};
         end
         default: begin
            res = attr;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/sgr_color_attribute_parser.sv @@
// Top level of the SGR color attribute parser: parameter accumulation, code
// application, commit of the attribute word and the result register.
// Depends on sgr_pkg.
`default_nettype none

// The block takes one byte of an SGR control sequence per item and can take
// an item in every cycle; a result appears in the cycle after its final letter is
// taken. Each byte passes through one multiply-by-ten-and-add or one code
// decode between the state registers, and the result sits in a single output
// register, so a new byte is taken whenever that register is empty or its
// item is taken in the same cycle. A stalled result holds off further input.
// The default attribute register is written through the csr port, which is
// always ready, and is meant to be written only while the block is idle.
module sgr_color_attribute_parser (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  sgr_pkg::sgr_req_type           req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output sgr_pkg::sgr_rsp_type                 rsp_data,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [sgr_pkg::AttrWidth-1:0]        csr_data
);

   logic [sgr_pkg::AttrWidth-1:0]  default_attr_ff, default_attr_in;
   logic [sgr_pkg::ParamWidth-1:0] param_accum_ff, param_accum_in;
   logic [sgr_pkg::AttrWidth-1:0]  attr_current_ff, attr_current_in;
   logic [sgr_pkg::AttrWidth-1:0]  attr_working_ff, attr_working_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   sgr_pkg::sgr_rsp_type           rsp_data_ff, rsp_data_in;

   logic                           req_fire;
   logic                           is_digit;
   logic                           is_semi;
   logic                           is_letter;
   logic                           is_commit;
   logic [sgr_pkg::ParamWidth-1:0] accum_start;
   logic [sgr_pkg::AttrWidth-1:0]  working_start;
   logic [sgr_pkg::ProdWidth-1:0]  accum_next;
   logic [sgr_pkg::AttrWidth-1:0]  applied_attr;

   // Handshakes: the output register frees up when its item is taken.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Byte classes.
   assign is_digit  = (req_data.seq_byte >= sgr_pkg::CharZero) &&
                      (req_data.seq_byte <= sgr_pkg::CharNine);
   assign is_semi   = (req_data.seq_byte == sgr_pkg::CharSemi);
   assign is_letter = ((req_data.seq_byte >= sgr_pkg::CharUpperA) &&
                       (req_data.seq_byte <= sgr_pkg::CharUpperZ)) ||
                      ((req_data.seq_byte >= sgr_pkg::CharLowerA) &&
                       (req_data.seq_byte <= sgr_pkg::CharLowerZ));
   assign is_commit = (req_data.seq_byte == sgr_pkg::CharM);

   // A start flag discards the partial sequence before the byte is handled.
   assign accum_start   = req_data.seq_start ? '0 : param_accum_ff;
   assign working_start = req_data.seq_start ? attr_current_ff : attr_working_ff;

   // Decimal accumulation as shift-and-add: p * 10 = p * 8 + p * 2.
   assign accum_next = {accum_start, 3'b000}
                     + {2'b00, accum_start, 1'b0}
                     + {{(sgr_pkg::ProdWidth - 4){1'b0}},
                        req_data.seq_byte[3:0]};

   assign applied_attr = sgr_pkg::apply_code(working_start, accum_start, default_attr_ff);

   // Next state of the parser and of the result register.
   always_comb begin
      default_attr_in = default_attr_ff;
      param_accum_in  = param_accum_ff;
      attr_current_in = attr_current_ff;
      attr_working_in = attr_working_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;

      if (csr_valid) begin
         default_attr_in = csr_data;
      end

      if (req_fire) begin
         param_accum_in  = accum_start;
         attr_working_in = working_start;
         if (is_digit) begin
            if (accum_next > {{(sgr_pkg::ProdWidth - sgr_pkg::ParamWidth){1'b0}},
                              sgr_pkg::ParamMax}) begin
               param_accum_in = sgr_pkg::ParamMax;
            end else begin
               param_accum_in = accum_next[sgr_pkg::ParamWidth-1:0];
            end
         end else if (is_semi) begin
            param_accum_in  = '0;
            attr_working_in = applied_attr;
         end else if (is_letter) begin
            param_accum_in = '0;
            if (is_commit) begin
               attr_current_in = applied_attr;
            end
            attr_working_in        = attr_current_in;
            rsp_valid_in           = 1'b1;
            rsp_data_in.attr_value = attr_current_in;
            rsp_data_in.final_byte = req_data.seq_byte;
            rsp_data_in.applied    = is_commit;
         end
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         default_attr_ff <= sgr_pkg::DefaultAttr;
         param_accum_ff  <= '0;
         attr_current_ff <= sgr_pkg::DefaultAttr;
         attr_working_ff <= sgr_pkg::DefaultAttr;
         rsp_valid_ff    <= 1'b0;
      end else begin
         default_attr_ff <= default_attr_in;
         param_accum_ff  <= param_accum_in;
         attr_current_ff <= attr_current_in;
         attr_working_ff <= attr_working_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ rtl/sgr_checker.sv @@
// Port-level checker for the SGR color attribute parser, with its bind.
// Depends on sgr_pkg and on the top level sgr_color_attribute_parser.
`default_nettype none

module sgr_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_ready,
   input wire sgr_pkg::sgr_req_type     req_data,
   input wire                           rsp_valid,
   input wire                           rsp_ready,
   input wire sgr_pkg::sgr_rsp_type     rsp_data
);

   logic req_fire;
   logic out_free;
   logic byte_digit;
   logic byte_letter;

   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid || rsp_ready;
   assign byte_digit  = (req_data.seq_byte >= sgr_pkg::CharZero) &&
                        (req_data.seq_byte <= sgr_pkg::CharNine);
   assign byte_letter = ((req_data.seq_byte >= sgr_pkg::CharUpperA) &&
                         (req_data.seq_byte <= sgr_pkg::CharUpperZ)) ||
                        ((req_data.seq_byte >= sgr_pkg::CharLowerA) &&
                         (req_data.seq_byte <= sgr_pkg::CharLowerZ));

   // A stalled result item holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // A digit never produces a result item.
   a_digit_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && byte_digit && out_free |=> !rsp_valid)
      else $error("digit produced a result item");

   // A final letter produces its result in the next cycle.
   a_letter_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && byte_letter |=> rsp_valid &&
         rsp_data.final_byte == $past(req_data.seq_byte))
      else $error("final letter did not produce its result item");

   // Commit is reported exactly for the letter m.
   a_applied_m: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.applied == (rsp_data.final_byte == sgr_pkg::CharM))
      else $error("applied flag does not match final letter");

endmodule

bind sgr_color_attribute_parser sgr_checker u_sgr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
